>>> rtl/bra_pkg.sv
// ----------------------------------------------------------------------------
// bra_pkg
// Shared widths, command codes and the scan unit's result word for the
// contiguous first-fit bitmap allocator.
// ----------------------------------------------------------------------------
package bra_pkg;

    // Map word geometry
    localparam int WORD_BITS    = 32;
    localparam int BIT_W        = 5;
    localparam int MAP_BITS_DEF = 1024;

    // Field widths
    localparam int CMD_W = 2;
    localparam int IDX_W = 10;
    localparam int LEN_W = 11;
    localparam int CFG_W = 11;
    localparam int POS_W = 12;
    localparam int RUN_W = 12;
    localparam int CNTF_W = 6;

    // Stream word widths
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 16;

    // Register reset value of the search bound
    localparam logic [CFG_W-1:0] BOUND_RST = 11'd1024;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET   = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_TEST  = 2'd2,
        CMD_ALLOC = 2'd3
    } cmd_t;

    // Result of evaluating one map word during a run search
    typedef struct packed {
        logic                 hit;
        logic [POS_W-1:0]     start;
        logic [RUN_W-1:0]     run_next;
        logic [WORD_BITS-1:0] cur_free;
    } scan_res_t;

endpackage

>>> rtl/bra_map_ram.sv
// ----------------------------------------------------------------------------
// bra_map_ram
// Usage map storage: one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module bra_map_ram
    import bra_pkg::*;
#(
    parameter int DEPTH  = MAP_BITS_DEF / WORD_BITS,
    parameter int ADDR_W = 5
)
(
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_W-1:0]    waddr,
    input  logic [WORD_BITS-1:0] wdata,
    input  logic                 re,
    input  logic [ADDR_W-1:0]    raddr,
    output logic [WORD_BITS-1:0] rdata
);

    logic [WORD_BITS-1:0] mem [DEPTH];
    logic [WORD_BITS-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/bra_scan_unit.sv
// ----------------------------------------------------------------------------
// bra_scan_unit
// Evaluates one map word per cycle for the run search. Short runs (up to one
// word) are found in a two-word window by doubling AND-shift masks; longer
// runs are tracked with a carried count of free entries.
// ----------------------------------------------------------------------------
module bra_scan_unit
    import bra_pkg::*;
(
    input  logic [WORD_BITS-1:0] word_data,
    input  logic [WORD_BITS-1:0] prev_free,
    input  logic [POS_W-1:0]     word_base,
    input  logic [CFG_W-1:0]     bound,
    input  logic [LEN_W-1:0]     want,
    input  logic [RUN_W-1:0]     run,
    output scan_res_t            res
);

    localparam int WIN_W = 2 * WORD_BITS;

    logic [POS_W-1:0]     room;
    logic [WORD_BITS-1:0] avail;
    logic [WORD_BITS-1:0] cur_free;
    logic [WIN_W-1:0]     pw [6];
    logic [WIN_W-1:0]     sel;
    logic [WIN_W-1:0]     runs;
    logic [WORD_BITS-1:0] hits;
    logic [2:0]           msb;
    logic [5:0]           pow;
    logic [5:0]           offset;
    logic [BIT_W-1:0]     first_end;
    logic [CNTF_W-1:0]    low_free;
    logic [CNTF_W-1:0]    high_free;
    logic [RUN_W-1:0]     run_sum;
    logic                 short_run;

    // Mask off entries at or above the search bound
    always_comb
    begin
        room = POS_W'(bound) - word_base;
        if (room >= POS_W'(WORD_BITS))
        begin
            avail = '1;
        end
        else
        begin
            avail = (WORD_BITS'(1) << room[BIT_W-1:0]) - WORD_BITS'(1);
        end
        cur_free = ~word_data & avail;
    end

    // Build power-of-two run masks over the two-word window
    always_comb
    begin
        pw[0] = {cur_free, prev_free};
        for (int i = 1; i < 6; i++)
        begin
            pw[i] = pw[i-1] & (pw[i-1] << (1 << (i - 1)));
        end
    end

    // Cover an arbitrary short length with two overlapping power masks
    always_comb
    begin
        msb = 3'd0;
        for (int k = 0; k < 6; k++)
        begin
            if (want[k])
            begin
                msb = 3'(k);
            end
        end
        pow    = 6'd1 << msb;
        offset = want[5:0] - pow;
        case (msb)
            3'd0:    sel = pw[0];
            3'd1:    sel = pw[1];
            3'd2:    sel = pw[2];
            3'd3:    sel = pw[3];
            3'd4:    sel = pw[4];
            default: sel = pw[5];
        endcase
        runs = sel & (sel << offset);
        hits = runs[WIN_W-1:WORD_BITS];
    end

    // Lowest run end in the current word
    always_comb
    begin
        first_end = '0;
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (hits[k])
            begin
                first_end = BIT_W'(k);
            end
        end
    end

    // Free entries at the bottom and top of the current word
    always_comb
    begin
        low_free  = CNTF_W'(WORD_BITS);
        high_free = CNTF_W'(WORD_BITS);
        for (int k = WORD_BITS - 1; k >= 0; k--)
        begin
            if (!cur_free[k])
            begin
                low_free = CNTF_W'(k);
            end
        end
        for (int k = 0; k < WORD_BITS; k++)
        begin
            if (!cur_free[k])
            begin
                high_free = CNTF_W'(WORD_BITS - 1 - k);
            end
        end
    end

    // Pick the result for short or long runs
    always_comb
    begin
        short_run = (want <= LEN_W'(WORD_BITS));
        run_sum   = run + RUN_W'(low_free);
        res.cur_free = cur_free;
        if (low_free == CNTF_W'(WORD_BITS))
        begin
            res.run_next = run + RUN_W'(WORD_BITS);
        end
        else
        begin
            res.run_next = RUN_W'(high_free);
        end
        if (short_run)
        begin
            res.hit   = |hits;
            res.start = word_base + POS_W'(first_end) + POS_W'(1) - POS_W'(want);
        end
        else
        begin
            res.hit   = (run_sum >= RUN_W'(want));
            res.start = word_base - POS_W'(run);
        end
    end

endmodule

>>> rtl/bitmap_run_allocator_core.sv
// ----------------------------------------------------------------------------
// bitmap_run_allocator_core
// Contiguous first-fit allocator over a usage bitmap held in word memory.
// Set, clear and test one entry, or allocate the lowest free run below the
// configured bound.
//
//   Channel  | Direction | Word contents (lowest bit first)
//   s_*      | in        | cmd[1:0], bit_index[11:2], run_length[22:12]
//   m_*      | out       | ok[0], run_start[10:1], bit_value[11]
//   cfg_*    | in        | bits_in_use[10:0], written when cfg_we is high
//
// Set, clear and test read the addressed word, then write or test it and respond.
// Allocate scans map words in order up to the word where the run ends, or, when
// no run fits, each word below the bound plus one step for the bound check; the
// words of the run are then marked by read-modify-write.
// The single map memory port pair limits each phase to one word a cycle.
// After reset a clearing pass writes all MAP_WORDS words, one a cycle;
// s_tready is low meanwhile.
// A waiting result sits in the output register; s_tready does not wait on it.
// ----------------------------------------------------------------------------
module bitmap_run_allocator_core
    import bra_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // cmd, bit_index, run_length
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // ok, run_start, bit_value
    input  logic                cfg_we,
    input  logic [CFG_W-1:0]    cfg_wdata  // bits_in_use
);

    localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
    localparam int ADDR_W    = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAP_WORDS + 1);
    localparam int SEG_W     = POS_W - BIT_W;

    typedef enum logic [6:0] {
        ST_CLEAR   = 7'b0000001,
        ST_IDLE    = 7'b0000010,
        ST_ACCESS  = 7'b0000100,
        ST_SCAN    = 7'b0001000,
        ST_MARK_RD = 7'b0010000,
        ST_MARK_WR = 7'b0100000,
        ST_RESP    = 7'b1000000
    } state_t;

    state_t               state_reg,       state_next;
    logic [CFG_W-1:0]     bits_in_use_reg, bits_in_use_next;
    cmd_t                 cmd_reg,         cmd_next;
    logic [IDX_W-1:0]     idx_reg,         idx_next;
    logic [LEN_W-1:0]     len_reg,         len_next;
    logic [CNT_W-1:0]     wcnt_reg,        wcnt_next;
    logic [RUN_W-1:0]     run_reg,         run_next;
    logic [WORD_BITS-1:0] prev_free_reg,   prev_free_next;
    logic [POS_W-1:0]     start_reg,       start_next;
    logic [POS_W-1:0]     end_reg,         end_next;
    logic                 res_ok_reg,      res_ok_next;
    logic                 res_val_reg,     res_val_next;
    logic                 m_tvalid_reg,    m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg,     m_tdata_next;

    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic                 ram_re;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [WORD_BITS-1:0] ram_rdata;

    logic                 in_accept;
    cmd_t                 in_cmd;
    logic [IDX_W-1:0]     in_idx;
    logic [LEN_W-1:0]     in_len;
    logic [CFG_W-1:0]     bound;
    logic [31:0]          base_full;
    logic                 in_range;
    logic                 idx_ok;
    logic [WORD_BITS-1:0] bit_sel;
    logic [SEG_W-1:0]     start_word;
    logic [SEG_W-1:0]     end_word;
    logic                 at_first;
    logic                 at_last;
    logic [BIT_W-1:0]     mark_lo;
    logic [BIT_W-1:0]     mark_hi;
    logic [WORD_BITS-1:0] mark_mask;
    logic                 out_free;
    scan_res_t            scan_res;

    // Unpack the input word
    assign in_cmd    = cmd_t'(s_tdata[1:0]);
    assign in_idx    = s_tdata[11:2];
    assign in_len    = s_tdata[22:12];
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Clamp the search bound to the map size
    assign bound = (32'(bits_in_use_reg) > 32'(MAP_BITS)) ? CFG_W'(MAP_BITS)
                                                           : bits_in_use_reg;
    assign base_full = 32'(wcnt_reg) << BIT_W;
    assign in_range  = base_full < 32'(bound);
    assign idx_ok    = 32'(idx_reg) < 32'(MAP_BITS);
    assign bit_sel   = WORD_BITS'(1) << idx_reg[BIT_W-1:0];

    // Per-word mark mask for the allocated run
    always_comb
    begin
        start_word = start_reg[POS_W-1:BIT_W];
        end_word   = end_reg[POS_W-1:BIT_W];
        at_first   = 32'(wcnt_reg) == 32'(start_word);
        at_last    = 32'(wcnt_reg) == 32'(end_word);
        mark_lo    = at_first ? start_reg[BIT_W-1:0] : '0;
        mark_hi    = at_last  ? end_reg[BIT_W-1:0]   : '1;
        mark_mask  = ({WORD_BITS{1'b1}} << mark_lo)
                   & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - mark_hi));
    end

    bra_map_ram #(
        .DEPTH  (MAP_WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bra_scan_unit u_scan_unit (
        .word_data (ram_rdata),
        .prev_free (prev_free_reg),
        .word_base (POS_W'(base_full)),
        .bound     (bound),
        .want      (len_reg),
        .run       (run_reg),
        .res       (scan_res)
    );

    // Sequencer and map port control
    always_comb
    begin
        state_next       = state_reg;
        bits_in_use_next = cfg_we ? cfg_wdata : bits_in_use_reg;
        cmd_next         = cmd_reg;
        idx_next         = idx_reg;
        len_next         = len_reg;
        wcnt_next        = wcnt_reg;
        run_next         = run_reg;
        prev_free_next   = prev_free_reg;
        start_next       = start_reg;
        end_next         = end_reg;
        res_ok_next      = res_ok_reg;
        res_val_next     = res_val_reg;
        m_tvalid_next    = m_tvalid_reg && !m_tready;
        m_tdata_next     = m_tdata_reg;

        ram_we    = 1'b0;
        ram_waddr = ADDR_W'(wcnt_reg);
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = ADDR_W'(wcnt_reg);

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                if (32'(wcnt_reg) == 32'(MAP_WORDS - 1))
                begin
                    wcnt_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    wcnt_next = wcnt_reg + CNT_W'(1);
                end
            end

            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next       = in_cmd;
                    idx_next       = in_idx;
                    len_next       = in_len;
                    wcnt_next      = '0;
                    run_next       = '0;
                    prev_free_next = '0;
                    start_next     = '0;
                    res_val_next   = 1'b0;
                    res_ok_next    = 1'b0;
                    ram_re         = 1'b1;
                    if (in_cmd == CMD_ALLOC)
                    begin
                        ram_raddr  = '0;
                        state_next = (in_len == '0) ? ST_RESP : ST_SCAN;
                    end
                    else
                    begin
                        ram_raddr  = ADDR_W'(in_idx[IDX_W-1:BIT_W]);
                        state_next = ST_ACCESS;
                    end
                end
            end

            ST_ACCESS:
            begin
                ram_waddr   = ADDR_W'(idx_reg[IDX_W-1:BIT_W]);
                res_ok_next = idx_ok;
                unique case (cmd_reg)
                    CMD_SET:
                    begin
                        ram_we    = idx_ok;
                        ram_wdata = ram_rdata | bit_sel;
                    end
                    CMD_CLEAR:
                    begin
                        ram_we    = idx_ok;
                        ram_wdata = ram_rdata & ~bit_sel;
                    end
                    CMD_TEST:
                    begin
                        res_val_next = idx_ok && ram_rdata[idx_reg[BIT_W-1:0]];
                    end
                    default:
                    begin
                        res_ok_next = 1'b0;
                    end
                endcase
                state_next = ST_RESP;
            end

            ST_SCAN:
            begin
                // Fetch the following word while this one is evaluated
                ram_raddr = ADDR_W'(wcnt_reg + CNT_W'(1));
                ram_re    = (32'(wcnt_reg) + 32'd1) < 32'(MAP_WORDS);
                if (!in_range)
                begin
                    res_ok_next = 1'b0;
                    start_next  = '0;
                    state_next  = ST_RESP;
                end
                else if (scan_res.hit)
                begin
                    start_next = scan_res.start;
                    end_next   = scan_res.start + POS_W'(len_reg) - POS_W'(1);
                    wcnt_next  = CNT_W'(scan_res.start[POS_W-1:BIT_W]);
                    state_next = ST_MARK_RD;
                end
                else
                begin
                    wcnt_next      = wcnt_reg + CNT_W'(1);
                    run_next       = scan_res.run_next;
                    prev_free_next = scan_res.cur_free;
                end
            end

            ST_MARK_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_MARK_WR;
            end

            ST_MARK_WR:
            begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | mark_mask;
                if (at_last)
                begin
                    res_ok_next = 1'b1;
                    state_next  = ST_RESP;
                end
                else
                begin
                    wcnt_next  = wcnt_reg + CNT_W'(1);
                    state_next = ST_MARK_RD;
                end
            end

            ST_RESP:
            begin
                // Hand the result over once the output register is free
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_DATA_W'({res_val_reg,
                                              res_ok_reg ? start_reg[IDX_W-1:0]
                                                         : {IDX_W{1'b0}},
                                              res_ok_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            bits_in_use_reg <= BOUND_RST;
            wcnt_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            bits_in_use_reg <= bits_in_use_next;
            wcnt_reg        <= wcnt_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        idx_reg       <= idx_next;
        len_reg       <= len_next;
        run_reg       <= run_next;
        prev_free_reg <= prev_free_next;
        start_reg     <= start_next;
        end_reg       <= end_next;
        res_ok_reg    <= res_ok_next;
        res_val_reg   <= res_val_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Marking never runs past the last word of the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK_WR) |-> (32'(wcnt_reg) <= 32'(end_word)))
        else $error("mark pass overran the run end word");

    // An allocated run lies wholly below the search bound
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MARK_RD) |-> (32'(end_reg) < 32'(bound)))
        else $error("allocated run crosses the search bound");

    // A zero-length allocate answers at once without scanning
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_cmd == CMD_ALLOC) && (in_len == '0))
            |=> (state_reg == ST_RESP))
        else $error("zero-length allocate started a scan");

endmodule
